// ===== design/assert_macros.svh =====
// Concurrent assertion helpers, clocked on i_clk and disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/rps_pkg.sv =====
`timescale 1ns / 1ps

package rps_pkg;

    localparam int TEMP_BITS   = 12;
    localparam int FRAC_BITS   = 8;
    localparam int FIX_W       = TEMP_BITS + FRAC_BITS;
    localparam int STEP_W      = FIX_W + 1;
    localparam int TIME_W      = 16;
    localparam int GAIN_W      = 16;
    localparam int PROD_W      = FIX_W + GAIN_W;
    localparam int PCT_SHIFT   = FRAC_BITS + 10;
    localparam int CNT_W       = $clog2(FIX_W);
    localparam int PHASE_W     = 3;
    localparam int PCT_W       = 7;
    localparam int DUTY_W      = 8;
    localparam int ELAPSED_W   = 16;
    localparam int NUM_TARGETS = 5;
    localparam int NUM_RAMPS   = 3;
    localparam int TARGETS_W   = NUM_TARGETS * TEMP_BITS;
    localparam int TIMES_W     = NUM_RAMPS * TIME_W;
    localparam int GAINS_W     = NUM_RAMPS * GAIN_W;
    localparam int CFG_DATA_W  = TARGETS_W;
    localparam int PCT_MAX     = 100;
    localparam int DUTY_RECIP  = 5243;
    localparam int DUTY_SHIFT  = 19;

    localparam logic [TEMP_BITS-1:0] FAULT_LIMIT = TEMP_BITS'(400 * 4);
    localparam logic [TEMP_BITS-1:0] SAFE_RESET  = TEMP_BITS'(200);
    localparam logic [DUTY_W-1:0]    FULL_DUTY   = DUTY_W'(255);

    typedef logic [1:0] t_cfg_index;
    localparam t_cfg_index CFG_TARGETS = 2'd0;
    localparam t_cfg_index CFG_TIMES   = 2'd1;
    localparam t_cfg_index CFG_GAINS   = 2'd2;
    localparam t_cfg_index CFG_SAFE    = 2'd3;

    typedef enum logic [PHASE_W-1:0] {
        PH_READY  = 3'd0,
        PH_PRE    = 3'd1,
        PH_SOAK   = 3'd2,
        PH_REFLOW = 3'd3,
        PH_COOL   = 3'd4,
        PH_DONE   = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_MUL,
        S_FIN
    } t_state;

    typedef struct packed {
        logic                 sample_due;
        logic [TEMP_BITS-1:0] temperature;
        logic                 button_pressed;
    } t_in_item;

    typedef struct packed {
        t_phase               phase;
        logic                 running;
        logic [PCT_W-1:0]     heater_percent;
        logic [DUTY_W-1:0]    heater_duty;
        logic [DUTY_W-1:0]    fan_duty;
        logic [TEMP_BITS-1:0] setpoint_now;
        logic [ELAPSED_W-1:0] elapsed_samples;
        logic                 sensor_fault;
    } t_out_item;

    function automatic logic [TEMP_BITS-1:0] target_sel(
        input logic [TARGETS_W-1:0] targets,
        input logic [PHASE_W-1:0]   k
    );
        logic [TEMP_BITS-1:0] t;
        unique case (k)
            3'd0:    t = targets[0*TEMP_BITS +: TEMP_BITS];
            3'd1:    t = targets[1*TEMP_BITS +: TEMP_BITS];
            3'd2:    t = targets[2*TEMP_BITS +: TEMP_BITS];
            3'd3:    t = targets[3*TEMP_BITS +: TEMP_BITS];
            default: t = targets[4*TEMP_BITS +: TEMP_BITS];
        endcase
        return t;
    endfunction

    function automatic logic [TIME_W-1:0] ramp_field(
        input logic [TIMES_W-1:0] packed_reg,
        input t_phase             p
    );
        logic [TIME_W-1:0] f;
        unique case (p)
            PH_PRE:    f = packed_reg[0*TIME_W +: TIME_W];
            PH_SOAK:   f = packed_reg[1*TIME_W +: TIME_W];
            PH_REFLOW: f = packed_reg[2*TIME_W +: TIME_W];
            default:   f = '0;
        endcase
        return f;
    endfunction

    // floor(pct * 255 / 100) through a reciprocal, exact for pct up to 100
    function automatic logic [DUTY_W-1:0] duty_of(input logic [PCT_W-1:0] pct);
        logic [14:0] scaled;
        logic [28:0] prod;
        scaled = 15'(pct) * 15'd255;
        prod   = 29'(scaled) * 29'(DUTY_RECIP);
        return prod[DUTY_SHIFT +: DUTY_W];
    endfunction

endpackage

// ===== design/reflow_profile_sequencer.sv =====
`timescale 1ns / 1ps
// The result is registered in S_FIN once the request is accepted; if a heating phase follows,
//   20 restoring divide steps, then 16 shift-add multiply steps on one shared adder, come first.
// Input ready only in idle, so a new request waits until S_FIN has loaded the result register.
// The result register lets the next request in while a result waits; S_FIN holds until it is taken.
// Reset (synchronous, active low): phase ready, stopped, elapsed count and setpoint zero,
//   targets/times/gains zero, safe temperature 200 quarter degrees.
module reflow_profile_sequencer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  rps_pkg::t_in_item            i_in,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output rps_pkg::t_out_item           o_out,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  rps_pkg::t_cfg_index          i_cfg_index,
    input  logic [rps_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import rps_pkg::*;

    logic [TARGETS_W-1:0]    r_targets;
    logic [TIMES_W-1:0]      r_times;
    logic [GAINS_W-1:0]      r_gains;
    logic [TEMP_BITS-1:0]    r_safe;

    logic                    r_run,      n_run;
    t_phase                  r_phase,    n_phase;
    logic [FIX_W-1:0]        r_setpoint, n_setpoint;
    logic signed [STEP_W-1:0] r_step,    n_step;
    logic [TEMP_BITS-1:0]    r_temp,     n_temp;
    logic [ELAPSED_W-1:0]    r_elapsed,  n_elapsed;
    logic                    r_fault,    n_fault;

    t_state                  r_state,    n_state;
    logic [CNT_W-1:0]        r_cnt,      n_cnt;
    logic [PROD_W-1:0]       r_acc,      n_acc;
    logic [FIX_W-1:0]        r_dividend, n_dividend;
    logic [TIME_W-1:0]       r_divisor,  n_divisor;
    logic                    r_neg,      n_neg;
    logic [FIX_W-1:0]        r_mcand,    n_mcand;
    logic [GAIN_W-1:0]       r_mplier,   n_mplier;
    t_out_item               r_out,      n_out;
    logic                    r_out_valid, n_out_valid;

    logic                    s_run;
    t_phase                  s_phase;
    logic [FIX_W-1:0]        s_setpoint;
    logic [TEMP_BITS-1:0]    s_temp;
    logic [ELAPSED_W-1:0]    s_elapsed;
    logic                    s_fault;
    logic [TEMP_BITS-1:0]    s_tgt;
    logic [FIX_W-1:0]        s_lim;
    logic signed [FIX_W+1:0] s_sum;
    logic                    s_heat;
    logic [TEMP_BITS-1:0]    s_tgt_new;
    logic [TEMP_BITS-1:0]    s_tgt_prev;
    logic signed [TEMP_BITS:0] s_diff;
    logic [TEMP_BITS-1:0]    s_mag;
    logic signed [FIX_W:0]   s_err;

    logic [PROD_W-1:0]       u_a;
    logic [PROD_W-1:0]       u_b;
    logic                    u_sub;
    logic [PROD_W:0]         u_y;

    logic [TIME_W:0]         rem_shift;
    logic                    qbit;
    logic [FIX_W-1:0]        quot;
    logic [PROD_W-PCT_SHIFT-1:0] pct_raw;
    logic [PCT_W-1:0]        pct;

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign u_y = u_sub ? ({1'b0, u_a} - {1'b0, u_b}) : ({1'b0, u_a} + {1'b0, u_b});

    always_comb begin
        s_temp    = i_in.sample_due ? i_in.temperature : r_temp;
        s_fault   = i_in.sample_due ? (i_in.temperature > FAULT_LIMIT) : r_fault;
        s_elapsed = r_elapsed;
        if (i_in.sample_due && r_run && (r_elapsed != '1)) begin
            s_elapsed = r_elapsed + ELAPSED_W'(1);
        end
        s_run      = r_run;
        s_phase    = r_phase;
        s_setpoint = r_setpoint;
        if (i_in.button_pressed) begin
            s_phase    = PH_PRE;
            s_run      = ~r_run;
            s_setpoint = {s_temp, {FRAC_BITS{1'b0}}};
        end
        s_tgt = target_sel(r_targets, s_phase);
        s_lim = {s_tgt, {FRAC_BITS{1'b0}}};
        s_sum = signed'({2'b00, s_setpoint}) + (FIX_W+2)'(r_step);
        if (s_run) begin
            if (s_phase != PH_COOL) begin
                if (i_in.sample_due) begin
                    if (s_sum > signed'({2'b00, s_lim})) begin
                        s_setpoint = s_lim;
                    end else if (s_sum < 0) begin
                        s_setpoint = '0;
                    end else begin
                        s_setpoint = s_sum[FIX_W-1:0];
                    end
                end
                if (s_temp >= s_tgt) begin
                    s_phase = t_phase'(s_phase + 3'd1);
                end
            end else if (s_temp < s_tgt) begin
                s_phase = PH_DONE;
            end
            if (s_phase == PH_DONE) begin
                s_run = 1'b0;
            end
        end else begin
            s_elapsed = '0;
            if (s_phase != PH_DONE || s_temp < r_safe) begin
                s_phase = PH_READY;
            end
        end
        s_heat = s_run && (s_phase == PH_PRE || s_phase == PH_SOAK || s_phase == PH_REFLOW);
        s_tgt_new  = target_sel(r_targets, s_phase);
        s_tgt_prev = target_sel(r_targets, s_phase - 3'd1);
        s_diff = signed'({1'b0, s_tgt_new}) - signed'({1'b0, s_tgt_prev});
        s_mag  = s_diff[TEMP_BITS] ? TEMP_BITS'(-s_diff) : TEMP_BITS'(s_diff);
        s_err  = signed'({1'b0, s_setpoint}) - signed'({1'b0, s_temp, {FRAC_BITS{1'b0}}});
    end

    assign rem_shift = {r_acc[TIME_W-1:0], r_dividend[FIX_W-1]};
    assign qbit      = ~u_y[PROD_W];
    assign quot      = {r_dividend[FIX_W-2:0], qbit};
    assign pct_raw   = r_acc[PROD_W-1:PCT_SHIFT];
    assign pct       = (pct_raw > (PROD_W-PCT_SHIFT)'(PCT_MAX)) ? PCT_W'(PCT_MAX)
                                                                : pct_raw[PCT_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_acc       = r_acc;
        n_dividend  = r_dividend;
        n_divisor   = r_divisor;
        n_neg       = r_neg;
        n_mcand     = r_mcand;
        n_mplier    = r_mplier;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        n_run       = r_run;
        n_phase     = r_phase;
        n_setpoint  = r_setpoint;
        n_step      = r_step;
        n_temp      = r_temp;
        n_elapsed   = r_elapsed;
        n_fault     = r_fault;
        o_in_ready  = 1'b0;
        u_a         = '0;
        u_b         = '0;
        u_sub       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_run      = s_run;
                    n_phase    = s_phase;
                    n_setpoint = s_setpoint;
                    n_temp     = s_temp;
                    n_elapsed  = s_elapsed;
                    n_fault    = s_fault;
                    n_acc      = '0;
                    n_cnt      = '0;
                    n_dividend = {s_mag, {FRAC_BITS{1'b0}}};
                    n_neg      = s_diff[TEMP_BITS];
                    n_divisor  = ramp_field(r_times, s_phase);
                    n_mplier   = ramp_field(r_gains, s_phase);
                    n_mcand    = (s_err > 0) ? s_err[FIX_W-1:0] : '0;
                    n_state    = s_heat ? S_DIV : S_FIN;
                end
            end
            S_DIV: begin
                u_a   = PROD_W'(rem_shift);
                u_b   = PROD_W'(r_divisor);
                u_sub = 1'b1;
                n_acc = qbit ? PROD_W'(u_y[TIME_W-1:0]) : PROD_W'(rem_shift[TIME_W-1:0]);
                n_dividend = quot;
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(FIX_W - 1)) begin
                    n_cnt   = '0;
                    n_acc   = '0;
                    n_state = S_MUL;
                    if (r_divisor == '0) begin
                        n_step = '0;
                    end else if (r_neg) begin
                        n_step = -signed'(STEP_W'(quot));
                    end else begin
                        n_step = signed'(STEP_W'(quot));
                    end
                end
            end
            S_MUL: begin
                u_a      = {r_acc[PROD_W-2:0], 1'b0};
                u_b      = r_mplier[GAIN_W-1] ? PROD_W'(r_mcand) : '0;
                n_acc    = u_y[PROD_W-1:0];
                n_mplier = {r_mplier[GAIN_W-2:0], 1'b0};
                n_cnt    = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(GAIN_W - 1)) begin
                    n_cnt   = '0;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.phase           = r_phase;
                    n_out.running         = r_run;
                    n_out.heater_percent  = pct;
                    n_out.heater_duty     = duty_of(pct);
                    n_out.fan_duty        = (r_run && r_phase == PH_COOL) ? FULL_DUTY : '0;
                    n_out.setpoint_now    = r_setpoint[FIX_W-1:FRAC_BITS];
                    n_out.elapsed_samples = r_elapsed;
                    n_out.sensor_fault    = r_fault;
                    n_out_valid           = 1'b1;
                    n_state               = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_run       <= 1'b0;
            r_phase     <= PH_READY;
            r_setpoint  <= '0;
            r_step      <= '0;
            r_temp      <= '0;
            r_elapsed   <= '0;
            r_fault     <= 1'b0;
            r_targets   <= '0;
            r_times     <= '0;
            r_gains     <= '0;
            r_safe      <= SAFE_RESET;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_run       <= n_run;
            r_phase     <= n_phase;
            r_setpoint  <= n_setpoint;
            r_step      <= n_step;
            r_temp      <= n_temp;
            r_elapsed   <= n_elapsed;
            r_fault     <= n_fault;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_TARGETS: r_targets <= i_cfg_data[TARGETS_W-1:0];
                    CFG_TIMES:   r_times   <= i_cfg_data[TIMES_W-1:0];
                    CFG_GAINS:   r_gains   <= i_cfg_data[GAINS_W-1:0];
                    CFG_SAFE:    r_safe    <= i_cfg_data[TEMP_BITS-1:0];
                    default:     r_safe    <= r_safe;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt      <= n_cnt;
        r_acc      <= n_acc;
        r_dividend <= n_dividend;
        r_divisor  <= n_divisor;
        r_neg      <= n_neg;
        r_mcand    <= n_mcand;
        r_mplier   <= n_mplier;
        r_out      <= n_out;
    end

`include "assert_macros.svh"

    `ASSERT_IMP(a_run_phase, r_run, (r_phase != PH_READY) && (r_phase != PH_DONE))
    `ASSERT_IMP(a_pct_range, r_out_valid, r_out.heater_percent <= PCT_W'(PCT_MAX))
    `ASSERT_IMP(a_fan_cool, r_out_valid && (r_out.fan_duty != '0),
                (r_out.phase == PH_COOL) && r_out.running)
    `ASSERT_NEXT(a_fin_load, (r_state == S_FIN) && (!r_out_valid || i_out_ready),
                 r_out_valid && (r_state == S_IDLE))

endmodule
